>>> hdl/mlfq_pkg.sv
// shared constants and types of the multilevel feedback thread scheduler
package mlfq_pkg;

   localparam int LEVELS_DEF      = 5;
   localparam int MAX_THREADS_DEF = 64;

   localparam int OP_W     = 3;
   localparam int TID_W    = 6;
   localparam int STATUS_W = 2;
   localparam int RLVL_W   = 3;
   localparam int SLICE_W  = 23;
   localparam int UNIT_W   = 20;
   localparam int PERIOD_W = 8;
   localparam int CSR_IDX_W = 1;

   localparam logic [UNIT_W-1:0]   SLICE_UNIT_RST   = 20'd25000;
   localparam logic [PERIOD_W-1:0] MERGE_PERIOD_RST = 8'd10;

   // operation codes
   localparam logic [OP_W-1:0] OP_CREATE = 3'd0;
   localparam logic [OP_W-1:0] OP_EXPIRE = 3'd1;
   localparam logic [OP_W-1:0] OP_YIELD  = 3'd2;
   localparam logic [OP_W-1:0] OP_EXIT   = 3'd3;
   localparam logic [OP_W-1:0] OP_BLOCK  = 3'd4;
   localparam logic [OP_W-1:0] OP_WAKE   = 3'd5;

   // result status codes
   localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_NOREADY  = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_BADWAKE  = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SLICE_UNIT   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MERGE_PERIOD = 1'b1;

   typedef enum logic [1:0] {
      SLOT_FREE,
      SLOT_READY,
      SLOT_RUN,
      SLOT_BLOCKED
   } slot_state_type;

endpackage

>>> hdl/mlfq_status_mem.sv
// per-slot thread state memory with valid bits standing in for the reset value
module mlfq_status_mem #(
   parameter int DEPTH = mlfq_pkg::MAX_THREADS_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     rd_en,
   input  logic [AW-1:0]            rd_addr,
   output mlfq_pkg::slot_state_type rd_state,
   input  logic                     wr_en,
   input  logic [AW-1:0]            wr_addr,
   input  mlfq_pkg::slot_state_type wr_state
);

   mlfq_pkg::slot_state_type state_mem [DEPTH];
   logic [DEPTH-1:0]         valid_ff;
   mlfq_pkg::slot_state_type rd_data_ff;
   logic                     rd_valid_ff;
   logic                     rd_zero_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         state_mem[wr_addr] <= wr_state;
      end
      if (rd_en) begin
         rd_data_ff  <= state_mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
         rd_zero_ff  <= (rd_addr == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // slot zero comes out of reset running, all others free
   assign rd_state = rd_valid_ff ? rd_data_ff :
                     (rd_zero_ff ? mlfq_pkg::SLOT_RUN : mlfq_pkg::SLOT_FREE);

endmodule

>>> hdl/mlfq_link_mem.sv
// list link memory, one next pointer per slot
module mlfq_link_mem #(
   parameter int DEPTH = mlfq_pkg::MAX_THREADS_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [AW-1:0] rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [AW-1:0] wr_data
);

   logic [AW-1:0] link_mem [DEPTH];
   logic [AW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         link_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= link_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/mlfq_ctrl.sv
// scheduler sequencer: level lists, list walk, merge, pick and result register
module mlfq_ctrl #(
   parameter int LEVELS      = mlfq_pkg::LEVELS_DEF,
   parameter int MAX_THREADS = mlfq_pkg::MAX_THREADS_DEF,
   parameter int SW          = $clog2(MAX_THREADS),
   parameter int LVW         = $clog2(LEVELS)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [mlfq_pkg::OP_W-1:0]         req_op,
   input  logic [mlfq_pkg::TID_W-1:0]        req_target_thread,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [mlfq_pkg::STATUS_W-1:0]     rsp_status,
   output logic [mlfq_pkg::TID_W-1:0]        rsp_created_thread,
   output logic                              rsp_switched,
   output logic [mlfq_pkg::TID_W-1:0]        rsp_run_thread,
   output logic [mlfq_pkg::RLVL_W-1:0]       rsp_run_level,
   output logic [mlfq_pkg::SLICE_W-1:0]      rsp_slice_length,
   input  logic                              csr_wr_en,
   input  logic [mlfq_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mlfq_pkg::UNIT_W-1:0]       csr_wr_data,
   output logic                              st_rd_en,
   output logic [SW-1:0]                     st_rd_addr,
   input  mlfq_pkg::slot_state_type          st_rd_state,
   output logic                              st_wr_en,
   output logic [SW-1:0]                     st_wr_addr,
   output mlfq_pkg::slot_state_type          st_wr_state,
   output logic                              lk_rd_en,
   output logic [SW-1:0]                     lk_rd_addr,
   input  logic [SW-1:0]                     lk_rd_data,
   output logic                              lk_wr_en,
   output logic [SW-1:0]                     lk_wr_addr,
   output logic [SW-1:0]                     lk_wr_data
);

   typedef enum logic [3:0] {
      S_IDLE, S_FIND, S_WAKE, S_ACT, S_WALK, S_WALK_CK, S_APPLY,
      S_PASS, S_MERGE, S_MERGE_END, S_PICK, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic [mlfq_pkg::OP_W-1:0] op_ff, op_in;
   logic [SW-1:0] tgt_ff, tgt_in;
   logic [SW:0]   scan_ff, scan_in;
   logic [SW-1:0] chk_ff, chk_in;
   logic          pend_ff, pend_in;
   logic [SW-1:0] p_ff, p_in;
   logic [SW-1:0] nxtc_ff, nxtc_in;
   logic [LVW-1:0] lv_ff, lv_in;
   logic [LVW-1:0] mlv_ff, mlv_in;
   logic          have_ff, have_in;
   logic [SW-1:0] h_ff, h_in;
   logic [SW-1:0] tl_ff, tl_in;
   logic [SW-1:0] head_ff [LEVELS];
   logic [SW-1:0] head_in [LEVELS];
   logic [SW-1:0] tail_ff [LEVELS];
   logic [SW-1:0] tail_in [LEVELS];
   logic [LEVELS-1:0] ne_ff, ne_in;
   logic [SW-1:0] run_ff, run_in;
   logic [LVW-1:0] run_lvl_ff, run_lvl_in;
   logic [mlfq_pkg::PERIOD_W-1:0] cd_ff, cd_in;
   logic [mlfq_pkg::UNIT_W-1:0]   unit_ff, unit_in;
   logic [mlfq_pkg::PERIOD_W-1:0] period_ff, period_in;
   logic [mlfq_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [SW-1:0]  res_created_ff, res_created_in;
   logic           res_sw_ff, res_sw_in;
   logic [SW-1:0]  res_run_ff, res_run_in;
   logic [LVW-1:0] res_lvl_ff, res_lvl_in;
   logic [mlfq_pkg::SLICE_W-1:0] res_slice_ff, res_slice_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [mlfq_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [SW-1:0]  rsp_created_ff, rsp_created_in;
   logic           rsp_sw_ff, rsp_sw_in;
   logic [SW-1:0]  rsp_run_ff, rsp_run_in;
   logic [LVW-1:0] rsp_lvl_ff, rsp_lvl_in;
   logic [mlfq_pkg::SLICE_W-1:0] rsp_slice_ff, rsp_slice_in;

   always_comb begin
      logic          found;
      logic [LVW-1:0] fl;
      logic [LVW-1:0] nl;
      logic [mlfq_pkg::PERIOD_W-1:0] cd_dec;
      logic [LVW:0]  fac;
      logic [LVW+mlfq_pkg::UNIT_W:0] prod;

      state_in = state_ff;
      op_in = op_ff;
      tgt_in = tgt_ff;
      scan_in = scan_ff;
      chk_in = chk_ff;
      pend_in = pend_ff;
      p_in = p_ff;
      nxtc_in = nxtc_ff;
      lv_in = lv_ff;
      mlv_in = mlv_ff;
      have_in = have_ff;
      h_in = h_ff;
      tl_in = tl_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      ne_in = ne_ff;
      run_in = run_ff;
      run_lvl_in = run_lvl_ff;
      cd_in = cd_ff;
      unit_in = unit_ff;
      period_in = period_ff;
      res_status_in = res_status_ff;
      res_created_in = res_created_ff;
      res_sw_in = res_sw_ff;
      res_run_in = res_run_ff;
      res_lvl_in = res_lvl_ff;
      res_slice_in = res_slice_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_created_in = rsp_created_ff;
      rsp_sw_in = rsp_sw_ff;
      rsp_run_in = rsp_run_ff;
      rsp_lvl_in = rsp_lvl_ff;
      rsp_slice_in = rsp_slice_ff;
      st_rd_en = 1'b0;
      st_rd_addr = run_ff;
      st_wr_en = 1'b0;
      st_wr_addr = run_ff;
      st_wr_state = mlfq_pkg::SLOT_FREE;
      lk_rd_en = 1'b0;
      lk_rd_addr = run_ff;
      lk_wr_en = 1'b0;
      lk_wr_addr = p_ff;
      lk_wr_data = nxtc_ff;
      found = 1'b0;
      fl = '0;
      nl = '0;
      cd_dec = cd_ff - 1'b1;
      fac = '0;
      prod = '0;

      if (csr_wr_en) begin
         unique case (csr_index)
            mlfq_pkg::CSR_SLICE_UNIT: unit_in = csr_wr_data;
            mlfq_pkg::CSR_MERGE_PERIOD: period_in = csr_wr_data[mlfq_pkg::PERIOD_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in = req_op;
               res_status_in = mlfq_pkg::STAT_OK;
               res_created_in = '0;
               res_sw_in = 1'b0;
               res_run_in = '0;
               res_lvl_in = '0;
               res_slice_in = '0;
               case (req_op) inside
                  mlfq_pkg::OP_CREATE: begin
                     scan_in = '0;
                     pend_in = 1'b0;
                     state_in = S_FIND;
                  end
                  mlfq_pkg::OP_WAKE: begin
                     if (32'(req_target_thread) < MAX_THREADS) begin
                        st_rd_en = 1'b1;
                        st_rd_addr = SW'(req_target_thread);
                        tgt_in = SW'(req_target_thread);
                        state_in = S_WAKE;
                     end else begin
                        res_status_in = mlfq_pkg::STAT_BADWAKE;
                        state_in = S_DONE;
                     end
                  end
                  mlfq_pkg::OP_EXPIRE, mlfq_pkg::OP_YIELD,
                  mlfq_pkg::OP_EXIT, mlfq_pkg::OP_BLOCK: begin
                     st_rd_en = 1'b1;
                     lk_rd_en = 1'b1;
                     state_in = S_ACT;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_FIND: begin
            if (pend_ff && st_rd_state == mlfq_pkg::SLOT_FREE) begin
               // lowest free slot: mark ready, append to level zero
               st_wr_en = 1'b1;
               st_wr_addr = chk_ff;
               st_wr_state = mlfq_pkg::SLOT_READY;
               if (ne_ff[0]) begin
                  lk_wr_en = 1'b1;
                  lk_wr_addr = tail_ff[0];
                  lk_wr_data = chk_ff;
               end else begin
                  head_in[0] = chk_ff;
                  ne_in[0] = 1'b1;
               end
               tail_in[0] = chk_ff;
               res_created_in = chk_ff;
               state_in = S_DONE;
            end else if (pend_ff && chk_ff == SW'(MAX_THREADS - 1)) begin
               res_status_in = mlfq_pkg::STAT_FULL;
               state_in = S_DONE;
            end else if (scan_ff < (SW+1)'(MAX_THREADS)) begin
               st_rd_en = 1'b1;
               st_rd_addr = scan_ff[SW-1:0];
               chk_in = scan_ff[SW-1:0];
               pend_in = 1'b1;
               scan_in = scan_ff + 1'b1;
            end
         end
         S_WAKE: begin
            if (st_rd_state == mlfq_pkg::SLOT_BLOCKED) begin
               st_wr_en = 1'b1;
               st_wr_addr = tgt_ff;
               st_wr_state = mlfq_pkg::SLOT_READY;
               if (ne_ff[0]) begin
                  lk_wr_en = 1'b1;
                  lk_wr_addr = tgt_ff;
                  lk_wr_data = head_ff[0];
               end else begin
                  tail_in[0] = tgt_ff;
                  ne_in[0] = 1'b1;
               end
               head_in[0] = tgt_ff;
            end else begin
               res_status_in = mlfq_pkg::STAT_BADWAKE;
            end
            state_in = S_DONE;
         end
         S_ACT: begin
            nxtc_in = lk_rd_data;
            lv_in = run_lvl_ff;
            if (st_rd_state != mlfq_pkg::SLOT_RUN) begin
               state_in = S_PASS;
            end else if (!ne_ff[run_lvl_ff]) begin
               state_in = S_APPLY;
            end else if (head_ff[run_lvl_ff] == run_ff) begin
               if (tail_ff[run_lvl_ff] == run_ff) begin
                  ne_in[run_lvl_ff] = 1'b0;
               end else begin
                  head_in[run_lvl_ff] = lk_rd_data;
               end
               state_in = S_APPLY;
            end else begin
               p_in = head_ff[run_lvl_ff];
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (p_ff == tail_ff[lv_ff]) begin
               state_in = S_APPLY;
            end else begin
               lk_rd_en = 1'b1;
               lk_rd_addr = p_ff;
               state_in = S_WALK_CK;
            end
         end
         S_WALK_CK: begin
            if (lk_rd_data == run_ff) begin
               // unlink the running thread behind its predecessor
               lk_wr_en = 1'b1;
               lk_wr_addr = p_ff;
               lk_wr_data = nxtc_ff;
               if (tail_ff[lv_ff] == run_ff) begin
                  tail_in[lv_ff] = p_ff;
               end
               state_in = S_APPLY;
            end else begin
               p_in = lk_rd_data;
               state_in = S_WALK;
            end
         end
         S_APPLY: begin
            st_wr_en = 1'b1;
            case (op_ff) inside
               mlfq_pkg::OP_EXPIRE, mlfq_pkg::OP_YIELD: begin
                  if (op_ff == mlfq_pkg::OP_YIELD || lv_ff == LVW'(LEVELS - 1)) begin
                     nl = LVW'(LEVELS - 1);
                  end else begin
                     nl = lv_ff + 1'b1;
                  end
                  st_wr_state = mlfq_pkg::SLOT_READY;
                  if (ne_ff[nl]) begin
                     lk_wr_en = 1'b1;
                     lk_wr_addr = tail_ff[nl];
                     lk_wr_data = run_ff;
                  end else begin
                     head_in[nl] = run_ff;
                     ne_in[nl] = 1'b1;
                  end
                  tail_in[nl] = run_ff;
               end
               mlfq_pkg::OP_EXIT: st_wr_state = mlfq_pkg::SLOT_FREE;
               default: st_wr_state = mlfq_pkg::SLOT_BLOCKED;
            endcase
            state_in = S_PASS;
         end
         S_PASS: begin
            if (cd_dec == '0) begin
               cd_in = period_ff;
               mlv_in = '0;
               have_in = 1'b0;
               h_in = '0;
               tl_in = '0;
               state_in = S_MERGE;
            end else begin
               cd_in = cd_dec;
               state_in = S_PICK;
            end
         end
         S_MERGE: begin
            if (ne_ff[mlv_ff]) begin
               if (have_ff) begin
                  lk_wr_en = 1'b1;
                  lk_wr_addr = tl_ff;
                  lk_wr_data = head_ff[mlv_ff];
               end else begin
                  h_in = head_ff[mlv_ff];
                  have_in = 1'b1;
               end
               tl_in = tail_ff[mlv_ff];
               ne_in[mlv_ff] = 1'b0;
            end
            if (mlv_ff == LVW'(LEVELS - 1)) begin
               state_in = S_MERGE_END;
            end else begin
               mlv_in = mlv_ff + 1'b1;
            end
         end
         S_MERGE_END: begin
            head_in[0] = h_ff;
            tail_in[0] = tl_ff;
            ne_in[0] = have_ff;
            state_in = S_PICK;
         end
         S_PICK: begin
            for (int i = LEVELS - 1; i >= 0; i--) begin
               if (ne_ff[i]) begin
                  found = 1'b1;
                  fl = LVW'(i);
               end
            end
            if (found) begin
               run_in = head_ff[fl];
               run_lvl_in = fl;
               st_wr_en = 1'b1;
               st_wr_addr = head_ff[fl];
               st_wr_state = mlfq_pkg::SLOT_RUN;
               fac = (LVW+1)'(fl) + 1'b1;
               prod = (LVW+mlfq_pkg::UNIT_W+1)'(fac) * (LVW+mlfq_pkg::UNIT_W+1)'(unit_ff);
               res_sw_in = 1'b1;
               res_run_in = head_ff[fl];
               res_lvl_in = fl;
               res_slice_in = mlfq_pkg::SLICE_W'(prod);
               res_status_in = mlfq_pkg::STAT_OK;
            end else begin
               res_status_in = mlfq_pkg::STAT_NOREADY;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_created_in = res_created_ff;
               rsp_sw_in = res_sw_ff;
               rsp_run_in = res_run_ff;
               rsp_lvl_in = res_lvl_ff;
               rsp_slice_in = res_slice_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff <= 1'b0;
         for (int i = 0; i < LEVELS; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
         end
         ne_ff <= LEVELS'(1);
         run_ff <= '0;
         run_lvl_ff <= '0;
         cd_ff <= mlfq_pkg::MERGE_PERIOD_RST;
         unit_ff <= mlfq_pkg::SLICE_UNIT_RST;
         period_ff <= mlfq_pkg::MERGE_PERIOD_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff <= pend_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         ne_ff <= ne_in;
         run_ff <= run_in;
         run_lvl_ff <= run_lvl_in;
         cd_ff <= cd_in;
         unit_ff <= unit_in;
         period_ff <= period_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff <= op_in;
      tgt_ff <= tgt_in;
      scan_ff <= scan_in;
      chk_ff <= chk_in;
      p_ff <= p_in;
      nxtc_ff <= nxtc_in;
      lv_ff <= lv_in;
      mlv_ff <= mlv_in;
      have_ff <= have_in;
      h_ff <= h_in;
      tl_ff <= tl_in;
      res_status_ff <= res_status_in;
      res_created_ff <= res_created_in;
      res_sw_ff <= res_sw_in;
      res_run_ff <= res_run_in;
      res_lvl_ff <= res_lvl_in;
      res_slice_ff <= res_slice_in;
      rsp_status_ff <= rsp_status_in;
      rsp_created_ff <= rsp_created_in;
      rsp_sw_ff <= rsp_sw_in;
      rsp_run_ff <= rsp_run_in;
      rsp_lvl_ff <= rsp_lvl_in;
      rsp_slice_ff <= rsp_slice_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_created_thread = mlfq_pkg::TID_W'(rsp_created_ff);
   assign rsp_switched = rsp_sw_ff;
   assign rsp_run_thread = mlfq_pkg::TID_W'(rsp_run_ff);
   assign rsp_run_level = mlfq_pkg::RLVL_W'(rsp_lvl_ff);
   assign rsp_slice_length = rsp_slice_ff;

endmodule

>>> hdl/multilevel_feedback_thread_scheduler.sv
// top level of the multilevel feedback thread scheduler
//
//  channel | direction | handshake                 | payload
//  req     | in        | req_valid / req_ready     | op, target_thread
//  rsp     | out       | rsp_valid / rsp_ready     | status, created_thread, switched,
//          |           |                           | run_thread, run_level, slice_length
//  csr     | in        | csr_wr_en (no wait)       | csr_index, csr_wr_data
//
// one item at a time; every beat in yields exactly one beat out
// create scans the state memory for the lowest free slot; wake checks the target
// expire/yield/exit/block walk the level list in the link memory (one dependent
// read per entry) unless nothing runs, plus a merge of all levels when due
// reset leaves slot 0 alone on level 0 and clears the valid bits, no clearing pass
// a finished result waits in the output register; a new beat is taken meanwhile
module multilevel_feedback_thread_scheduler #(
   parameter int LEVELS      = mlfq_pkg::LEVELS_DEF,
   parameter int MAX_THREADS = mlfq_pkg::MAX_THREADS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [mlfq_pkg::OP_W-1:0]      req_op,
   input  logic [mlfq_pkg::TID_W-1:0]     req_target_thread,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [mlfq_pkg::STATUS_W-1:0]  rsp_status,
   output logic [mlfq_pkg::TID_W-1:0]     rsp_created_thread,
   output logic                           rsp_switched,
   output logic [mlfq_pkg::TID_W-1:0]     rsp_run_thread,
   output logic [mlfq_pkg::RLVL_W-1:0]    rsp_run_level,
   output logic [mlfq_pkg::SLICE_W-1:0]   rsp_slice_length,
   input  logic                           csr_wr_en,
   input  logic [mlfq_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mlfq_pkg::UNIT_W-1:0]    csr_wr_data
);

   localparam int SW = $clog2(MAX_THREADS);

   // slot state memory port
   logic                     st_rd_en;
   logic [SW-1:0]            st_rd_addr;
   mlfq_pkg::slot_state_type st_rd_state;
   logic                     st_wr_en;
   logic [SW-1:0]            st_wr_addr;
   mlfq_pkg::slot_state_type st_wr_state;

   // link memory port
   logic          lk_rd_en;
   logic [SW-1:0] lk_rd_addr;
   logic [SW-1:0] lk_rd_data;
   logic          lk_wr_en;
   logic [SW-1:0] lk_wr_addr;
   logic [SW-1:0] lk_wr_data;

   // free/ready/running/blocked per slot; invalid entries read as reset state
   mlfq_status_mem #(
      .DEPTH (MAX_THREADS)
   ) u_status_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (st_rd_en),
      .rd_addr  (st_rd_addr),
      .rd_state (st_rd_state),
      .wr_en    (st_wr_en),
      .wr_addr  (st_wr_addr),
      .wr_state (st_wr_state)
   );

   // next pointers of the level lists
   mlfq_link_mem #(
      .DEPTH (MAX_THREADS)
   ) u_link_mem (
      .clock   (clock),
      .rd_en   (lk_rd_en),
      .rd_addr (lk_rd_addr),
      .rd_data (lk_rd_data),
      .wr_en   (lk_wr_en),
      .wr_addr (lk_wr_addr),
      .wr_data (lk_wr_data)
   );

   // sequencer: read, modify, write back
   mlfq_ctrl #(
      .LEVELS      (LEVELS),
      .MAX_THREADS (MAX_THREADS)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_target_thread  (req_target_thread),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_created_thread (rsp_created_thread),
      .rsp_switched       (rsp_switched),
      .rsp_run_thread     (rsp_run_thread),
      .rsp_run_level      (rsp_run_level),
      .rsp_slice_length   (rsp_slice_length),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data),
      .st_rd_en           (st_rd_en),
      .st_rd_addr         (st_rd_addr),
      .st_rd_state        (st_rd_state),
      .st_wr_en           (st_wr_en),
      .st_wr_addr         (st_wr_addr),
      .st_wr_state        (st_wr_state),
      .lk_rd_en           (lk_rd_en),
      .lk_rd_addr         (lk_rd_addr),
      .lk_rd_data         (lk_rd_data),
      .lk_wr_en           (lk_wr_en),
      .lk_wr_addr         (lk_wr_addr),
      .lk_wr_data         (lk_wr_data)
   );

endmodule

>>> dv/multilevel_feedback_thread_scheduler_tb.sv
// self-checking testbench of the multilevel feedback thread scheduler
module multilevel_feedback_thread_scheduler_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NLVL    = mlfq_pkg::LEVELS_DEF;
   localparam int NSLOT   = mlfq_pkg::MAX_THREADS_DEF;
   localparam int IDLE_MAX = 5000;    // cycles without any beat before giving up
   localparam int DRAIN    = 200;     // worst walk plus a merge, with margin
   localparam int HOLD_LEN = 400;     // long receiver stall
   localparam int HOLD_AT  = 600;     // response count at which the stall starts
   localparam int PHASE_ITEMS = 310;

   // unused op codes, kept by name
   localparam logic [mlfq_pkg::OP_W-1:0] OP_NOP6 = 3'd6;
   localparam logic [mlfq_pkg::OP_W-1:0] OP_NOP7 = 3'd7;

   typedef struct packed {
      logic [mlfq_pkg::STATUS_W-1:0] status;
      logic [mlfq_pkg::TID_W-1:0]    created_thread;
      logic                          switched;
      logic [mlfq_pkg::TID_W-1:0]    run_thread;
      logic [mlfq_pkg::RLVL_W-1:0]   run_level;
      logic [mlfq_pkg::SLICE_W-1:0]  slice_length;
   } sched_rsp_type;

   typedef struct {
      logic [mlfq_pkg::OP_W-1:0]  op;
      logic [mlfq_pkg::TID_W-1:0] tgt;
      bit                         typed;   // response spelled out in the row
      sched_rsp_type              rsp;
   } stim_row_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [mlfq_pkg::OP_W-1:0]       req_op = '0;
   logic [mlfq_pkg::TID_W-1:0]      req_target_thread = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [mlfq_pkg::STATUS_W-1:0]   rsp_status;
   logic [mlfq_pkg::TID_W-1:0]      rsp_created_thread;
   logic                            rsp_switched;
   logic [mlfq_pkg::TID_W-1:0]      rsp_run_thread;
   logic [mlfq_pkg::RLVL_W-1:0]     rsp_run_level;
   logic [mlfq_pkg::SLICE_W-1:0]    rsp_slice_length;
   logic                            csr_wr_en = 1'b0;
   logic [mlfq_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [mlfq_pkg::UNIT_W-1:0]     csr_wr_data = '0;

   always #4 clock = ~clock;

   multilevel_feedback_thread_scheduler uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_op(req_op), .req_target_thread(req_target_thread),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_created_thread(rsp_created_thread),
      .rsp_switched(rsp_switched), .rsp_run_thread(rsp_run_thread),
      .rsp_run_level(rsp_run_level), .rsp_slice_length(rsp_slice_length),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   // ---------------------------------------------------------------
   // scheduler shadow state
   // ---------------------------------------------------------------
   logic [mlfq_pkg::TID_W-1:0]  link_mem [NSLOT];
   logic [mlfq_pkg::RLVL_W-1:0] lvl_of   [NSLOT];
   mlfq_pkg::slot_state_type    slot_st  [NSLOT];
   logic [mlfq_pkg::TID_W-1:0]  q_head   [NLVL];
   logic [mlfq_pkg::TID_W-1:0]  q_tail   [NLVL];
   bit                          q_busy   [NLVL];
   logic [mlfq_pkg::TID_W-1:0]  cur_thread;
   logic [7:0]                  merge_cnt;
   int                          live_cnt;
   logic [mlfq_pkg::UNIT_W-1:0]   unit_reg;
   logic [mlfq_pkg::PERIOD_W-1:0] period_reg;

   sched_rsp_type grant_q [$];   // responses still owed by the block
   int  err_cnt = 0;
   int  rsp_seen = 0;
   bit  calm = 1'b0;          // no idling on either side while set

   function automatic void shadow_reset();
      for (int i = 0; i < NSLOT; i++) begin
         link_mem[i] = '0;
         lvl_of[i]   = '0;
         slot_st[i]  = mlfq_pkg::SLOT_FREE;
      end
      for (int l = 0; l < NLVL; l++) begin
         q_head[l] = '0;
         q_tail[l] = '0;
         q_busy[l] = 1'b0;
      end
      slot_st[0] = mlfq_pkg::SLOT_RUN;
      q_busy[0]  = 1'b1;
      cur_thread = '0;
      merge_cnt  = 8'd10;
      live_cnt   = 0;
      unit_reg   = mlfq_pkg::SLICE_UNIT_RST;
      period_reg = mlfq_pkg::MERGE_PERIOD_RST;
   endfunction

   function automatic void lst_append(int lv, logic [mlfq_pkg::TID_W-1:0] t);
      if (q_busy[lv]) link_mem[q_tail[lv]] = t;
      else begin
         q_head[lv] = t;
         q_busy[lv] = 1'b1;
      end
      q_tail[lv] = t;
   endfunction

   function automatic void lst_push_front(int lv, logic [mlfq_pkg::TID_W-1:0] t);
      if (q_busy[lv]) link_mem[t] = q_head[lv];
      else begin
         q_tail[lv] = t;
         q_busy[lv] = 1'b1;
      end
      q_head[lv] = t;
   endfunction

   function automatic void lst_remove(int lv, logic [mlfq_pkg::TID_W-1:0] t);
      logic [mlfq_pkg::TID_W-1:0] p, q;
      if (!q_busy[lv]) return;
      if (q_head[lv] == t) begin
         if (q_tail[lv] == t) q_busy[lv] = 1'b0;
         else q_head[lv] = link_mem[t];
         return;
      end
      p = q_head[lv];
      for (int n = 0; n < NSLOT; n++) begin
         if (p == q_tail[lv]) return;
         q = link_mem[p];
         if (q == t) begin
            link_mem[p] = link_mem[t];
            if (q_tail[lv] == t) q_tail[lv] = p;
            return;
         end
         p = q;
      end
   endfunction

   // chain every level, in order, onto level 0
   function automatic void merge_all();
      bit have;
      logic [mlfq_pkg::TID_W-1:0] h, tl;
      have = 1'b0;
      h = '0;
      tl = '0;
      for (int l = 0; l < NLVL; l++) begin
         if (!q_busy[l]) continue;
         if (have) link_mem[tl] = q_head[l];
         else begin
            h = q_head[l];
            have = 1'b1;
         end
         tl = q_tail[l];
         q_busy[l] = 1'b0;
      end
      q_head[0] = h;
      q_tail[0] = tl;
      q_busy[0] = have;
      for (int i = 0; i < NSLOT; i++)
         if (slot_st[i] == mlfq_pkg::SLOT_READY || slot_st[i] == mlfq_pkg::SLOT_RUN)
            lvl_of[i] = '0;
   endfunction

   // advance the shadow by one beat and return the response it owes
   function automatic sched_rsp_type sched_step(logic [mlfq_pkg::OP_W-1:0] op,
                                                logic [mlfq_pkg::TID_W-1:0] tgt);
      sched_rsp_type r;
      int free_slot, old_lv, new_lv;
      logic [mlfq_pkg::TID_W-1:0] c;
      r = '0;
      if (op == mlfq_pkg::OP_CREATE) begin
         free_slot = -1;
         for (int i = 0; i < NSLOT; i++)
            if (free_slot < 0 && slot_st[i] == mlfq_pkg::SLOT_FREE) free_slot = i;
         if (free_slot < 0) r.status = mlfq_pkg::STAT_FULL;
         else begin
            slot_st[free_slot] = mlfq_pkg::SLOT_READY;
            lvl_of[free_slot]  = '0;
            lst_append(0, free_slot[mlfq_pkg::TID_W-1:0]);
            if (live_cnt < 127) live_cnt++;
            r.created_thread = free_slot[mlfq_pkg::TID_W-1:0];
         end
      end else if (op == mlfq_pkg::OP_WAKE) begin
         if (slot_st[tgt] == mlfq_pkg::SLOT_BLOCKED) begin
            slot_st[tgt] = mlfq_pkg::SLOT_READY;
            lvl_of[tgt]  = '0;
            lst_push_front(0, tgt);
         end else r.status = mlfq_pkg::STAT_BADWAKE;
      end else if (op inside {mlfq_pkg::OP_EXPIRE, mlfq_pkg::OP_YIELD,
                              mlfq_pkg::OP_EXIT, mlfq_pkg::OP_BLOCK}) begin
         c = cur_thread;
         if (slot_st[c] == mlfq_pkg::SLOT_RUN) begin
            old_lv = lvl_of[c];
            if (old_lv >= NLVL) old_lv = NLVL - 1;
            lst_remove(old_lv, c);
            if (op == mlfq_pkg::OP_EXPIRE || op == mlfq_pkg::OP_YIELD) begin
               new_lv = (op == mlfq_pkg::OP_YIELD) ? NLVL - 1 : old_lv + 1;
               if (new_lv > NLVL - 1) new_lv = NLVL - 1;
               lvl_of[c]  = new_lv[mlfq_pkg::RLVL_W-1:0];
               slot_st[c] = mlfq_pkg::SLOT_READY;
               lst_append(new_lv, c);
            end else if (op == mlfq_pkg::OP_EXIT) begin
               slot_st[c] = mlfq_pkg::SLOT_FREE;
               lvl_of[c]  = '0;
               if (live_cnt > 0) live_cnt--;
            end else slot_st[c] = mlfq_pkg::SLOT_BLOCKED;
         end
         merge_cnt = merge_cnt - 8'd1;
         if (merge_cnt == 8'd0) begin
            merge_cnt = period_reg;
            merge_all();
         end
         r.status = mlfq_pkg::STAT_NOREADY;
         for (int l = 0; l < NLVL; l++) begin
            if (q_busy[l]) begin
               cur_thread = q_head[l];
               slot_st[q_head[l]] = mlfq_pkg::SLOT_RUN;
               r.status       = mlfq_pkg::STAT_OK;
               r.switched     = 1'b1;
               r.run_thread   = q_head[l];
               r.run_level    = l[mlfq_pkg::RLVL_W-1:0];
               r.slice_length = mlfq_pkg::SLICE_W'((l + 1) * unit_reg);
               break;
            end
         end
      end
      return r;
   endfunction

   // ---------------------------------------------------------------
   // sender side
   // ---------------------------------------------------------------
   function automatic int draw_gap();
      return calm ? 0 : $urandom_range(0, 11);
   endfunction

   // one request beat; the row's typed response wins over the shadow when given
   task automatic send_beat(logic [mlfq_pkg::OP_W-1:0] op, logic [mlfq_pkg::TID_W-1:0] tgt,
                            bit typed = 1'b0, sched_rsp_type typed_rsp = '0);
      int gap;
      sched_rsp_type r;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_target_thread <= tgt;
      do @(posedge clock); while (!req_ready);
      r = sched_step(op, tgt);
      grant_q.push_back(typed ? typed_rsp : r);
   endtask

   // idle the request side until every response is back, then let walks settle
   task automatic quiesce();
      req_valid <= 1'b0;
      while (grant_q.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic write_regs(logic [mlfq_pkg::UNIT_W-1:0] unit,
                             logic [mlfq_pkg::PERIOD_W-1:0] period);
      quiesce();
      csr_wr_en   <= 1'b1;
      csr_index   <= mlfq_pkg::CSR_SLICE_UNIT;
      csr_wr_data <= unit;
      @(posedge clock);
      unit_reg = unit;
      csr_index   <= mlfq_pkg::CSR_MERGE_PERIOD;
      csr_wr_data <= mlfq_pkg::UNIT_W'(period);
      @(posedge clock);
      period_reg = period;
      csr_wr_en <= 1'b0;
   endtask

   // mostly aimed at a blocked slot, otherwise any slot
   function automatic logic [mlfq_pkg::TID_W-1:0] pick_wake();
      int blocked [$];
      for (int i = 0; i < NSLOT; i++)
         if (slot_st[i] == mlfq_pkg::SLOT_BLOCKED) blocked.push_back(i);
      if (blocked.size() != 0 && $urandom_range(0, 9) < 7)
         return mlfq_pkg::TID_W'(blocked[$urandom_range(0, blocked.size() - 1)]);
      return mlfq_pkg::TID_W'($urandom_range(0, NSLOT - 1));
   endfunction

   // op mix; create_pct raised in the phase that fills the table
   function automatic logic [mlfq_pkg::OP_W-1:0] pick_op(int create_pct);
      int d;
      d = $urandom_range(0, 99);
      if (d < create_pct) return mlfq_pkg::OP_CREATE;
      d = $urandom_range(0, 99);
      if (d < 27) return mlfq_pkg::OP_EXPIRE;
      if (d < 40) return mlfq_pkg::OP_YIELD;
      if (d < 55) return mlfq_pkg::OP_EXIT;
      if (d < 72) return mlfq_pkg::OP_BLOCK;
      if (d < 94) return mlfq_pkg::OP_WAKE;
      return (d < 97) ? OP_NOP6 : OP_NOP7;
   endfunction

   stim_row_type dir_rows [$];

   task automatic build_rows();
      stim_row_type row;
      logic [mlfq_pkg::OP_W-1:0] ops [] = '{
         mlfq_pkg::OP_EXPIRE, OP_NOP6, OP_NOP7, mlfq_pkg::OP_WAKE, mlfq_pkg::OP_CREATE,
         mlfq_pkg::OP_YIELD, mlfq_pkg::OP_BLOCK, mlfq_pkg::OP_WAKE, mlfq_pkg::OP_CREATE,
         mlfq_pkg::OP_CREATE, mlfq_pkg::OP_EXPIRE, mlfq_pkg::OP_EXPIRE, mlfq_pkg::OP_EXPIRE,
         mlfq_pkg::OP_EXPIRE, mlfq_pkg::OP_EXPIRE, mlfq_pkg::OP_BLOCK, mlfq_pkg::OP_WAKE,
         mlfq_pkg::OP_EXIT, mlfq_pkg::OP_EXIT, mlfq_pkg::OP_EXIT, mlfq_pkg::OP_EXIT,
         mlfq_pkg::OP_EXPIRE, mlfq_pkg::OP_CREATE, mlfq_pkg::OP_WAKE};
      logic [mlfq_pkg::TID_W-1:0] tgts [] = '{
         6'd0, 6'd0, 6'd63, 6'd63, 6'd0, 6'd0, 6'd0, 6'd1, 6'd0, 6'd0, 6'd0, 6'd0,
         6'd0, 6'd0, 6'd0, 6'd0, 6'd2, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0};
      foreach (ops[i]) begin
         row.op = ops[i];
         row.tgt = tgts[i];
         row.typed = 1'b0;
         row.rsp = '0;
         dir_rows.push_back(row);
      end
      // right after reset slot 0 runs alone at level 0: expiry drops it to level 1
      dir_rows[0].typed = 1'b1;
      dir_rows[0].rsp = '{mlfq_pkg::STAT_OK, 6'd0, 1'b1, 6'd0, 3'd1, 23'd50000};
      // unused ops answer with an all-zero ok
      dir_rows[1].typed = 1'b1;
      dir_rows[2].typed = 1'b1;
      // slot 63 was never blocked
      dir_rows[3].typed = 1'b1;
      dir_rows[3].rsp.status = mlfq_pkg::STAT_BADWAKE;
      // first create takes the lowest free slot
      dir_rows[4].typed = 1'b1;
      dir_rows[4].rsp.created_thread = 6'd1;
   endtask

   // ---------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------
   initial begin
      logic [mlfq_pkg::UNIT_W-1:0]   units   [] = '{20'd1, 20'hFFFFF, 20'd1000000,
                                                   20'd0, 20'd7};
      logic [mlfq_pkg::PERIOD_W-1:0] periods [] = '{8'd1, 8'd0, 8'd255, 8'd0, 8'd3};
      int create_pct;
      shadow_reset();
      build_rows();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) send_beat(dir_rows[i].op, dir_rows[i].tgt, dir_rows[i].typed,
                                      dir_rows[i].rsp);

      // random phases, each under its own register setting
      for (int ph = 0; ph <= units.size(); ph++) begin
         if (ph > 0) begin
            if (ph == 4) write_regs(mlfq_pkg::UNIT_W'($urandom_range(1, 1000000)),
                                    mlfq_pkg::PERIOD_W'($urandom_range(1, 255)));
            else write_regs(units[ph - 1], periods[ph - 1]);
         end
         calm = (ph == 2);
         create_pct = (ph == 1) ? 60 : 22;   // phase 1 drives the table to full
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            logic [mlfq_pkg::OP_W-1:0] op;
            op = pick_op(create_pct);
            send_beat(op, (op == mlfq_pkg::OP_WAKE) ? pick_wake() :
                          mlfq_pkg::TID_W'($urandom_range(0, 63)));
         end
      end

      quiesce();
      if (err_cnt == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

   // ---------------------------------------------------------------
   // receiver side: random gaps plus one long stall to back up the block
   // ---------------------------------------------------------------
   int rsp_wait = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_wait = (rsp_seen == HOLD_AT) ? HOLD_LEN : draw_gap();
         end else if (rsp_wait > 0) rsp_wait--;
         rsp_ready <= (rsp_wait == 0);
      end
   end

   // response check, field by field against the oldest owed beat
   always @(posedge clock) begin
      sched_rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_seen++;
         if (grant_q.size() == 0) begin
            $error("response beat with nothing owed");
            err_cnt++;
         end else begin
            e = grant_q.pop_front();
            if (rsp_status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_status);
               err_cnt++;
            end
            if (rsp_created_thread !== e.created_thread) begin
               $error("created_thread exp %0d got %0d", e.created_thread, rsp_created_thread);
               err_cnt++;
            end
            if (rsp_switched !== e.switched) begin
               $error("switched exp %0d got %0d", e.switched, rsp_switched);
               err_cnt++;
            end
            if (rsp_run_thread !== e.run_thread) begin
               $error("run_thread exp %0d got %0d", e.run_thread, rsp_run_thread);
               err_cnt++;
            end
            if (rsp_run_level !== e.run_level) begin
               $error("run_level exp %0d got %0d", e.run_level, rsp_run_level);
               err_cnt++;
            end
            if (rsp_slice_length !== e.slice_length) begin
               $error("slice_length exp %0d got %0d", e.slice_length, rsp_slice_length);
               err_cnt++;
            end
         end
      end
   end

   // watchdog on cycles with no beat on any channel
   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_MAX) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

endmodule
